// ===== rtl/cubic_bezier_spline_eval_core_assert.svh =====
// Assertion macros used by the knot table of the spline evaluator RTL.
`ifndef CUBIC_BEZIER_SPLINE_EVAL_CORE_ASSERT_SVH
`define CUBIC_BEZIER_SPLINE_EVAL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CBSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/cbse_pkg.sv =====
// Types and constants of the cubic Bezier spline evaluator.
package cbse_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int VEC_W     = 3 * COORD_W;
    localparam int CPT_W     = COORD_W + 1;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int TP_W      = 33;
    localparam int SQ_W      = 2 * T_W;
    localparam int M_W       = SQ_W + 1;
    localparam int WGT_W     = T_W + 1;
    localparam int PROD_W    = WGT_W + 1 + CPT_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RES_W     = 16;
    localparam int TSTEP_W   = 17;
    localparam int CFG_W     = 17;
    localparam int IDX_W     = 4;

    localparam logic [T_W-1:0] ONE_T  = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0] HALF_T = T_W'(1) << (FRAC_BITS - 1);

    localparam logic [RES_W-1:0]   RESOLUTION_RST = 16'd1000;
    localparam logic [TSTEP_W-1:0] T_STEP_RST     = 17'd66;

    localparam logic CFG_RESOLUTION = 1'b0;
    localparam logic CFG_T_STEP     = 1'b1;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SETCTL = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_POINT  = 2'd0,
        ST_ACK    = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        logic    vld;
        t_status status;
    } t_ctl;

    typedef logic signed [CPT_W-1:0]   t_cpt;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [WGT_W-1:0]          t_wgt;

endpackage

// ===== rtl/cubic_bezier_spline_eval_core.sv =====
// Top level of the cubic Bezier spline evaluator.
// The core holds up to MAX_KNOTS knots, each a Q16.16 point with a control vector,
// in synchronous knot memories, and answers every request with exactly one result.
// Append, set-control and clear requests write the table and are acknowledged with
// status 1; an evaluate request on segment i at step j returns the cubic Bezier
// point between knots i and i+1 at t = min(j * t_step, 1.0) with status 0, each
// coordinate rounded and saturated to 32 bits. A full table, a control index past
// the stored knots, a segment without a following knot and a step at or above the
// resolution give status 2 with zero coordinates and change nothing. The core takes
// one request per cycle while the result output is not stalled; a result passes
// through six register stages: the memory read, the control point register, the
// register that lines the points up with the three weight stages, the point
// multipliers, the sum and the output register. A request that writes the
// table is visible to the very next request, so no ordering rules apply. While the
// result output is stalled the whole pipeline holds. The configuration registers
// (index 0 resolution, index 1 t_step) may be written only while no request is in
// flight.
module cubic_bezier_spline_eval_core #(
    parameter int MAX_KNOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // index[3:0], step[19:4], point_x/y/z[115:20], ctrl_x/y/z[211:116], zero pad
    input  logic [215:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // curve_x[31:0], curve_y[63:32], curve_z[95:64]
    output logic [95:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [cbse_pkg::CFG_W-1:0] i_cfg_wdata
);
    import cbse_pkg::*;

    localparam int DEPTH = 5;

    logic                en, acc;
    logic [RES_W-1:0]    r_resolution;
    logic [TSTEP_W-1:0]  r_t_step;
    t_status             status0;
    t_ctl                r_ctl [DEPTH];
    t_ctl                r_out;
    t_cpt                pts [4][3];
    t_wgt                w [4];
    t_coord              curve [3];
    logic [VEC_W-1:0]    r_out_data;

    // The pipeline moves whenever the output register is empty or being drained.
    assign en              = !r_out.vld || i_m_axis_tready;
    assign acc             = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= RESOLUTION_RST;
            r_t_step     <= T_STEP_RST;
            r_out        <= '{vld: 1'b0, status: ST_ACK};
            for (int s = 0; s < DEPTH; s++) begin
                r_ctl[s] <= '{vld: 1'b0, status: ST_ACK};
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RESOLUTION) begin
                    r_resolution <= i_cfg_wdata[RES_W-1:0];
                end else begin
                    r_t_step <= i_cfg_wdata[TSTEP_W-1:0];
                end
            end
            if (en) begin
                r_ctl[0] <= '{vld: acc, status: status0};
                for (int s = 1; s < DEPTH; s++) begin
                    r_ctl[s] <= r_ctl[s-1];
                end
                r_out <= r_ctl[DEPTH-1];
            end
        end
    end

    // Coordinates are forced to zero for every result that is not a curve point.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ctl[DEPTH-1].status == ST_POINT) begin
                r_out_data <= {curve[2], curve[1], curve[0]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    cbse_table #(.MAX_KNOTS(MAX_KNOTS)) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_acc        (acc),
        .i_cmd        (i_s_axis_tuser),
        .i_idx        (i_s_axis_tdata[3:0]),
        .i_step       (i_s_axis_tdata[19:4]),
        .i_resolution (r_resolution),
        .i_point      (i_s_axis_tdata[115:20]),
        .i_ctrl       (i_s_axis_tdata[211:116]),
        .o_status     (status0),
        .o_pts        (pts)
    );

    cbse_weights u_weights (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_step   (i_s_axis_tdata[19:4]),
        .i_t_step (r_t_step),
        .o_w      (w)
    );

    cbse_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (w),
        .i_pts   (pts),
        .o_curve (curve)
    );

    assign o_m_axis_tvalid = r_out.vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out.status;

endmodule

// ===== rtl/cbse_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module cbse_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cbse_table.sv =====
// Knot table: knot count, request checks, knot memories and control point forming.
`include "cubic_bezier_spline_eval_core_assert.svh"
module cbse_table #(
    parameter int MAX_KNOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_acc,
    input  logic [1:0]                  i_cmd,
    input  logic [cbse_pkg::IDX_W-1:0]  i_idx,
    input  logic [cbse_pkg::RES_W-1:0]  i_step,
    input  logic [cbse_pkg::RES_W-1:0]  i_resolution,
    input  logic [cbse_pkg::VEC_W-1:0]  i_point,
    input  logic [cbse_pkg::VEC_W-1:0]  i_ctrl,
    output cbse_pkg::t_status           o_status,
    output cbse_pkg::t_cpt              o_pts [4][3]
);
    import cbse_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int WW = (CW > IDX_W + 1) ? CW : IDX_W + 1;

    logic [CW-1:0] r_count, n_count;
    logic [WW-1:0] idx_w, idx_n, count_w;
    logic          app_ok, set_ok;
    logic          pt_we, cv_we;
    logic [AW-1:0] cv_waddr, raddr_a, raddr_b;
    logic [VEC_W-1:0] pt_a, pt_b, cv_a, cv_b;
    t_cpt          r_pts [4][3];
    t_status       status;

    assign idx_w   = WW'(i_idx);
    assign idx_n   = idx_w + WW'(1);
    assign count_w = WW'(r_count);
    assign app_ok  = (r_count < CW'(MAX_KNOTS));
    assign set_ok  = (idx_w < count_w);

    always_comb begin
        unique case (t_cmd'(i_cmd))
            CMD_APPEND: status = app_ok ? ST_ACK : ST_REJECT;
            CMD_SETCTL: status = set_ok ? ST_ACK : ST_REJECT;
            CMD_EVAL:   status = (idx_n < count_w && i_step < i_resolution) ?
                                 ST_POINT : ST_REJECT;
            CMD_CLEAR:  status = ST_ACK;
            default:    status = ST_REJECT;
        endcase
    end
    assign o_status = status;

    assign pt_we    = i_acc && t_cmd'(i_cmd) == CMD_APPEND && app_ok;
    assign cv_we    = pt_we || (i_acc && t_cmd'(i_cmd) == CMD_SETCTL && set_ok);
    assign cv_waddr = pt_we ? r_count[AW-1:0] : idx_w[AW-1:0];
    assign raddr_a  = idx_w[AW-1:0];
    assign raddr_b  = idx_n[AW-1:0];

    always_comb begin
        n_count = r_count;
        if (i_acc) begin
            if (t_cmd'(i_cmd) == CMD_CLEAR) begin
                n_count = '0;
            end else if (pt_we) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Each read port has its own copy, so a segment's two knots come out together.
    cbse_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KNOTS)) u_pt_a (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(r_count[AW-1:0]), .i_wdata(i_point),
        .i_re(i_en), .i_raddr(raddr_a), .o_rdata(pt_a));
    cbse_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KNOTS)) u_pt_b (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(r_count[AW-1:0]), .i_wdata(i_point),
        .i_re(i_en), .i_raddr(raddr_b), .o_rdata(pt_b));
    cbse_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KNOTS)) u_cv_a (
        .i_clk(i_clk), .i_we(cv_we), .i_waddr(cv_waddr), .i_wdata(i_ctrl),
        .i_re(i_en), .i_raddr(raddr_a), .o_rdata(cv_a));
    cbse_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KNOTS)) u_cv_b (
        .i_clk(i_clk), .i_we(cv_we), .i_waddr(cv_waddr), .i_wdata(i_ctrl),
        .i_re(i_en), .i_raddr(raddr_b), .o_rdata(cv_b));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_pts[0][c] <= CPT_W'(signed'(pt_a[c*COORD_W +: COORD_W]));
                r_pts[1][c] <= CPT_W'(signed'(pt_a[c*COORD_W +: COORD_W]))
                             - CPT_W'(signed'(cv_a[c*COORD_W +: COORD_W]));
                r_pts[2][c] <= CPT_W'(signed'(pt_b[c*COORD_W +: COORD_W]))
                             + CPT_W'(signed'(cv_b[c*COORD_W +: COORD_W]));
                r_pts[3][c] <= CPT_W'(signed'(pt_b[c*COORD_W +: COORD_W]));
            end
        end
    end
    assign o_pts = r_pts;

    `CBSE_ASSERT_NOW(a_write_needs_accept, i_clk, i_rst_n, cv_we,
        i_acc && status == ST_ACK, "knot memory written without an acknowledged request")
    `CBSE_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_acc && t_cmd'(i_cmd) == CMD_CLEAR,
        r_count == '0, "clear did not empty the table")
    `CBSE_ASSERT_NEXT(a_append_counts, i_clk, i_rst_n, pt_we,
        r_count == $past(r_count) + CW'(1), "append did not advance the knot count")

endmodule

// ===== rtl/cbse_weights.sv =====
// Bernstein weight pipeline: t from step and increment, then the four cubic weights.
module cbse_weights (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cbse_pkg::RES_W-1:0]    i_step,
    input  logic [cbse_pkg::TSTEP_W-1:0]  i_t_step,
    output cbse_pkg::t_wgt                o_w [4]
);
    import cbse_pkg::*;

    logic [TP_W-1:0] r_tp;
    logic [T_W-1:0]  t, u, r_t, r_u, t2, u2;
    logic [SQ_W-1:0] r_tt, r_uu;
    logic [M_W-1:0]  ut, ut2, r_m [4];

    always_comb begin
        t = (r_tp > TP_W'(ONE_T)) ? ONE_T : r_tp[T_W-1:0];
        u = ONE_T - t;
    end

    assign t2  = T_W'((r_tt + SQ_W'(HALF_T)) >> FRAC_BITS);
    assign u2  = T_W'((r_uu + SQ_W'(HALF_T)) >> FRAC_BITS);
    assign ut  = M_W'(u2) * M_W'(r_t);
    assign ut2 = M_W'(r_u) * M_W'(t2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tp   <= TP_W'(i_step) * TP_W'(i_t_step);
            r_t    <= t;
            r_u    <= u;
            r_tt   <= SQ_W'(t) * SQ_W'(t);
            r_uu   <= SQ_W'(u) * SQ_W'(u);
            r_m[0] <= M_W'(u2) * M_W'(r_u);
            r_m[1] <= (ut << 1) + ut;
            r_m[2] <= (ut2 << 1) + ut2;
            r_m[3] <= M_W'(t2) * M_W'(r_t);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_w[k] = WGT_W'((r_m[k] + M_W'(HALF_T)) >> FRAC_BITS);
        end
    end

endmodule

// ===== rtl/cbse_blend.sv =====
// Weighted sum of the four control points per coordinate, rounded and saturated.
module cbse_blend (
    input  logic            i_clk,
    input  logic            i_en,
    input  cbse_pkg::t_wgt  i_w [4],
    input  cbse_pkg::t_cpt  i_pts [4][3],
    output cbse_pkg::t_coord o_curve [3]
);
    import cbse_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(HALF_T);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(64'sh8000_0000);

    t_cpt                      r_pts [4][3];
    logic signed [PROD_W-1:0]  r_prod [4][3];
    logic signed [ACC_W-1:0]   r_acc [3];
    logic signed [ACC_W-1:0]   rs [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pts <= i_pts;
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[k][c] <= PROD_W'(signed'({1'b0, i_w[k]})) * PROD_W'(r_pts[k][c]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= ACC_W'(r_prod[0][c]) + ACC_W'(r_prod[1][c])
                          + ACC_W'(r_prod[2][c]) + ACC_W'(r_prod[3][c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rs[c] = (r_acc[c] + HALF_ACC) >>> FRAC_BITS;
            if (rs[c] > SAT_HI) begin
                o_curve[c] = t_coord'(SAT_HI[COORD_W-1:0]);
            end else if (rs[c] < SAT_LO) begin
                o_curve[c] = t_coord'(SAT_LO[COORD_W-1:0]);
            end else begin
                o_curve[c] = rs[c][COORD_W-1:0];
            end
        end
    end

endmodule

// ===== dv/cbse_checker.sv =====
// Checker that predicts and compares the results of the spline evaluator.
module cbse_checker #(
    parameter int MAX_KNOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [215:0]       i_s_tdata,
    input  logic [1:0]         i_s_tuser,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [95:0]        i_m_tdata,
    input  logic [1:0]         i_m_tuser,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [cbse_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import cbse_pkg::*;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        t_status     status;
    } t_curve_res;

    logic signed [31:0] knot_pt[MAX_KNOTS][3];
    logic signed [31:0] knot_cv[MAX_KNOTS][3];
    int                 knots_stored;
    int unsigned        steps_per_seg;
    int unsigned        t_inc;
    t_curve_res         curve_q[$];

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Bernstein weights in Q1.16, then one weighted sum per axis.
    function automatic t_curve_res bezier_point(int unsigned seg, int unsigned stp);
        t_curve_res r;
        longint unsigned t, u, t2, u2;
        longint w0, w1, w2, w3, p0, p1, p2, p3, acc;
        t = longint'(stp) * longint'(t_inc);
        if (t > 65536) begin
            t = 65536;
        end
        u  = 65536 - t;
        t2 = (t * t + 32768) >> 16;
        u2 = (u * u + 32768) >> 16;
        w0 = (u2 * u + 32768) >> 16;
        w1 = (3 * u2 * t + 32768) >> 16;
        w2 = (3 * u * t2 + 32768) >> 16;
        w3 = (t2 * t + 32768) >> 16;
        for (int c = 0; c < 3; c++) begin
            p0  = knot_pt[seg][c];
            p1  = p0 - longint'(knot_cv[seg][c]);
            p3  = knot_pt[seg+1][c];
            p2  = p3 + longint'(knot_cv[seg+1][c]);
            acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
            case (c)
                0: r.cx = clip32((acc + 32768) >>> 16);
                1: r.cy = clip32((acc + 32768) >>> 16);
                default: r.cz = clip32((acc + 32768) >>> 16);
            endcase
        end
        r.status = ST_POINT;
        return r;
    endfunction

    function automatic t_curve_res apply_request(t_cmd cmd, logic [215:0] d);
        t_curve_res  r;
        int unsigned idx, stp;
        idx = d[3:0];
        stp = d[19:4];
        r.cx = '0;
        r.cy = '0;
        r.cz = '0;
        r.status = ST_REJECT;
        case (cmd)
            CMD_APPEND: begin
                if (knots_stored < MAX_KNOTS) begin
                    for (int c = 0; c < 3; c++) begin
                        knot_pt[knots_stored][c] = d[20+32*c +: 32];
                        knot_cv[knots_stored][c] = d[116+32*c +: 32];
                    end
                    knots_stored++;
                    r.status = ST_ACK;
                end
            end
            CMD_SETCTL: begin
                if (idx < knots_stored) begin
                    for (int c = 0; c < 3; c++) begin
                        knot_cv[idx][c] = d[116+32*c +: 32];
                    end
                    r.status = ST_ACK;
                end
            end
            CMD_CLEAR: begin
                knots_stored = 0;
                r.status = ST_ACK;
            end
            default: begin
                if (idx + 1 < knots_stored && stp < steps_per_seg) begin
                    r = bezier_point(idx, stp);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_curve_res want;
        if (!i_rst_n) begin
            knots_stored  = 0;
            steps_per_seg = RESOLUTION_RST;
            t_inc         = T_STEP_RST;
            o_errors      = 0;
            curve_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RESOLUTION) begin
                    steps_per_seg = i_cfg_wdata[RES_W-1:0];
                end else begin
                    t_inc = i_cfg_wdata[TSTEP_W-1:0];
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (curve_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    want = curve_q.pop_front();
                    if (i_m_tdata[31:0] !== want.cx) begin
                        $error("curve_x expected %h got %h", want.cx, i_m_tdata[31:0]);
                        o_errors++;
                    end
                    if (i_m_tdata[63:32] !== want.cy) begin
                        $error("curve_y expected %h got %h", want.cy, i_m_tdata[63:32]);
                        o_errors++;
                    end
                    if (i_m_tdata[95:64] !== want.cz) begin
                        $error("curve_z expected %h got %h", want.cz, i_m_tdata[95:64]);
                        o_errors++;
                    end
                    if (i_m_tuser !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_m_tuser);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                curve_q = {curve_q, apply_request(t_cmd'(i_s_tuser), i_s_tdata)};
            end
        end
        o_pending <= curve_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives requests and configuration and reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbse_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [215:0]       s_tdata = '0;
    logic [1:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [95:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_we = 1'b0;
    logic               cfg_idx = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    int                 pending;
    int                 errors;

    // Stimulus-side view of the table fill and the current step count, used only
    // to steer requests toward the accepted cases.
    int                 fill;
    int unsigned        seg_steps;
    bit                 calm;
    bit                 hold_req;
    bit                 hold_done;
    int                 quiet_cycles;

    always #5 i_clk = ~i_clk;

    cubic_bezier_spline_eval_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    cbse_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // A coordinate: a quarter full-range random, a quarter modest values so that the
    // curve stays clear of saturation, and half the two extremes.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
        endcase
    endfunction

    // Sends one request; valid stays high afterward unless a gap is chosen next time.
    task automatic send_request(t_cmd cmd, int unsigned idx, int unsigned stp,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, cz, cy, cx, pz, py, px, 16'(stp), 4'(idx)};
        do @(posedge i_clk); while (!s_tready);
        case (cmd)
            CMD_APPEND: if (fill < 16) fill++;
            CMD_CLEAR:  fill = 0;
            default: ;
        endcase
    endtask

    task automatic send_random(t_cmd cmd, int unsigned idx, int unsigned stp);
        send_request(cmd, idx, stp, pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord());
    endtask

    // Register writes happen only with the pipeline drained.
    task automatic write_reg(logic idx, int unsigned val);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RESOLUTION) begin
            seg_steps = val & 16'hFFFF;
        end
    endtask

    // An evaluate on a populated table: mostly legal segment and step, with the
    // step edge and the rejections mixed in.
    task automatic send_eval();
        int unsigned seg, stp;
        seg = (fill >= 2) ? $urandom_range(0, fill - 2) : 0;
        if ($urandom_range(0, 9) == 0) begin
            seg = $urandom_range(fill > 0 ? fill - 1 : 0, 15);
        end
        case ($urandom_range(0, 9))
            0: stp = seg_steps - 1;
            1: stp = (seg_steps < 65536) ? $urandom_range(seg_steps, 65535) : 0;
            2: stp = 0;
            default: stp = $urandom_range(0, seg_steps - 1);
        endcase
        send_random(CMD_EVAL, seg, stp);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 5000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned res_set[6] = '{1000, 1, 65535, 65535, 256, 0};
        int unsigned inc_set[6] = '{66, 65536, 1, 65536, 256, 0};
        int unsigned body;
        fill         = 0;
        seg_steps    = RESOLUTION_RST;
        calm         = 1'b0;
        hold_req     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset configuration: empty table, extremes, full table.
        send_random(CMD_EVAL, 0, 0);
        send_random(CMD_SETCTL, 0, 0);
        send_request(CMD_APPEND, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_random(CMD_EVAL, 0, 0);
        send_request(CMD_APPEND, 15, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_random(CMD_EVAL, 0, 0);
        send_random(CMD_EVAL, 0, 500);
        send_random(CMD_EVAL, 0, 999);
        send_random(CMD_EVAL, 0, 1000);
        send_random(CMD_EVAL, 15, 16'hFFFF);
        send_random(CMD_EVAL, 1, 10);
        send_random(CMD_SETCTL, 0, 0);
        send_random(CMD_SETCTL, 2, 0);
        send_random(CMD_SETCTL, 15, 0);
        send_random(CMD_EVAL, 0, 300);
        while (fill < 16) send_random(CMD_APPEND, 0, 0);
        send_random(CMD_APPEND, 0, 0);
        send_random(CMD_EVAL, 14, 999);
        send_random(CMD_EVAL, 15, 1);
        send_random(CMD_SETCTL, 15, 0);
        send_random(CMD_CLEAR, 0, 0);
        send_random(CMD_EVAL, 0, 1);

        // Random phases, each under its own configuration.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                res_set[5] = $urandom_range(1, 65535);
                inc_set[5] = $urandom_range(1, 65536);
                calm = 1'b1;
            end
            write_reg(CFG_RESOLUTION, res_set[ph]);
            write_reg(CFG_T_STEP, inc_set[ph]);
            send_random(CMD_CLEAR, 0, 0);
            repeat ($urandom_range(2, 17)) send_random(CMD_APPEND, 0, 0);
            body = 0;
            while (body < 80) begin
                if (ph == 2 && body == 20) begin
                    hold_req = 1'b1;
                end
                case ($urandom_range(0, 19))
                    0, 1: send_random(CMD_SETCTL, $urandom_range(0, 15), $urandom);
                    2: send_random(CMD_APPEND, $urandom, $urandom);
                    3: begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_random(CMD_CLEAR, $urandom, $urandom);
                            repeat ($urandom_range(2, 16)) send_random(CMD_APPEND, 0, 0);
                        end else begin
                            send_random(CMD_SETCTL, $urandom_range(0, fill), 0);
                        end
                    end
                    default: send_eval();
                endcase
                body++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
